[rtl/frame_time_fusion_assert.svh]
// assertion macros for the frame time fusion block
// expects clk and rst_n in the scope of each use; compiled out under SYNTHESIS
`ifndef FRAME_TIME_FUSION_ASSERT_SVH
`define FRAME_TIME_FUSION_ASSERT_SVH
`ifndef SYNTHESIS
`define FTF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame_time_fusion assertion failed");
`define FTF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame_time_fusion assertion failed");
`else
`define FTF_ASSERT_IMP(lbl, ante, cons)
`define FTF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/ftf_pkg.sv]
// shared types, constants and microcode rom of the frame time fusion block
// no dependencies
package ftf_pkg;

  localparam int TW     = 32;
  localparam int KW     = 16;
  localparam int PW     = 64;
  localparam int ACCW   = 97;
  localparam int DENW   = 65;
  localparam int CFG_AW = 4;
  localparam int UPCW   = 5;
  localparam int CNTW   = 5;

  localparam logic [KW-1:0] KEEP_RST  = 16'd64881;
  localparam logic [KW-1:0] MAXDEV_RST = 16'd13107;
  localparam logic [TW-1:0] LIMIT_RST = 32'd284360;
  localparam logic [TW-1:0] NOISE_RST = 32'd33554432;
  localparam logic [TW-1:0] KEEP_ONE  = 32'h0001_0000;
  localparam logic [ACCW-1:0] ROUND_HALF = 97'd32768;
  localparam logic [CNTW-1:0] DIV_LAST = CNTW'(TW - 1);

  typedef enum logic [1:0] {
    REG_AVG_KEEP  = 2'd0,
    REG_MAX_DEV   = 2'd1,
    REG_GPU_LIMIT = 2'd2,
    REG_NOISE     = 2'd3
  } reg_idx_t;

  typedef logic [UPCW-1:0] upc_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_KEEP_AC, MUL_REST_C, MUL_KEEP_AG, MUL_REST_G, MUL_DEV,
    MUL_SQ, MUL_C_DGL, MUL_C_DGH, MUL_G_DCL, MUL_G_DCH
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_RND, ACC_ADD_LO, ACC_ADD_HI, ACC_LOAD
  } acc_op_t;

  typedef enum logic [1:0] {
    D_HOLD, D_GAP, D_CPREV, D_GPREV
  } dsel_t;

  typedef enum logic [3:0] {
    WR_NONE, WR_AVGC, WR_AVGG, WR_FUSE, WR_DC, WR_DG, WR_DEN,
    WR_RES_FUSE, WR_RES_CPU
  } wr_t;

  typedef enum logic [1:0] {
    DIV_NONE, DIV_INIT, DIV_STEP
  } div_op_t;

  typedef enum logic [2:0] {
    JC_NEXT, JC_JUMP, JC_WAIT_IN, JC_SKIP, JC_LOOP, JC_OUT
  } jc_t;

  typedef struct packed {
    jc_t     jc;
    upc_t    target;
    mul_op_t mul;
    acc_op_t acc;
    dsel_t   dsel;
    wr_t     wr;
    div_op_t div;
  } ctl_t;

  typedef struct packed {
    ctl_t cw;
    logic go;
  } uop_t;

  typedef struct packed {
    logic in_valid;
    logic fuse;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [KW-1:0] keep;
    logic [KW-1:0] max_dev;
    logic [TW-1:0] gpu_limit;
    logic [TW-1:0] noise;
  } cfg_t;

  localparam upc_t UPC_WAIT = 5'd0;
  localparam upc_t UPC_LOOP = 5'd18;
  localparam upc_t UPC_CPU  = 5'd20;

  function automatic ctl_t mk(jc_t jc, upc_t tgt, mul_op_t m, acc_op_t a, dsel_t d,
                              wr_t w, div_op_t v);
    ctl_t c;
    c = '{jc: jc, target: tgt, mul: m, acc: a, dsel: d, wr: w, div: v};
    return c;
  endfunction

  function automatic ctl_t ucode(upc_t pc);
    ctl_t c;
    unique case (pc)
      5'd0:  c = mk(JC_WAIT_IN, UPC_WAIT, MUL_NONE, ACC_HOLD, D_HOLD, WR_NONE, DIV_NONE);
      5'd1:  c = mk(JC_NEXT, UPC_WAIT, MUL_KEEP_AC, ACC_HOLD, D_HOLD, WR_NONE, DIV_NONE);
      5'd2:  c = mk(JC_NEXT, UPC_WAIT, MUL_REST_C, ACC_RND, D_HOLD, WR_NONE, DIV_NONE);
      5'd3:  c = mk(JC_NEXT, UPC_WAIT, MUL_KEEP_AG, ACC_ADD_LO, D_HOLD, WR_NONE, DIV_NONE);
      5'd4:  c = mk(JC_NEXT, UPC_WAIT, MUL_REST_G, ACC_RND, D_HOLD, WR_AVGC, DIV_NONE);
      5'd5:  c = mk(JC_NEXT, UPC_WAIT, MUL_NONE, ACC_ADD_LO, D_HOLD, WR_NONE, DIV_NONE);
      5'd6:  c = mk(JC_NEXT, UPC_WAIT, MUL_NONE, ACC_HOLD, D_HOLD, WR_AVGG, DIV_NONE);
      5'd7:  c = mk(JC_NEXT, UPC_WAIT, MUL_DEV, ACC_HOLD, D_GAP, WR_NONE, DIV_NONE);
      5'd8:  c = mk(JC_NEXT, UPC_WAIT, MUL_NONE, ACC_HOLD, D_CPREV, WR_FUSE, DIV_NONE);
      5'd9:  c = mk(JC_SKIP, UPC_CPU, MUL_SQ, ACC_HOLD, D_GPREV, WR_NONE, DIV_NONE);
      5'd10: c = mk(JC_NEXT, UPC_WAIT, MUL_SQ, ACC_HOLD, D_HOLD, WR_DC, DIV_NONE);
      5'd11: c = mk(JC_NEXT, UPC_WAIT, MUL_NONE, ACC_HOLD, D_HOLD, WR_DG, DIV_NONE);
      5'd12: c = mk(JC_NEXT, UPC_WAIT, MUL_C_DGL, ACC_HOLD, D_HOLD, WR_DEN, DIV_NONE);
      5'd13: c = mk(JC_NEXT, UPC_WAIT, MUL_C_DGH, ACC_LOAD, D_HOLD, WR_NONE, DIV_NONE);
      5'd14: c = mk(JC_NEXT, UPC_WAIT, MUL_G_DCL, ACC_ADD_HI, D_HOLD, WR_NONE, DIV_NONE);
      5'd15: c = mk(JC_NEXT, UPC_WAIT, MUL_G_DCH, ACC_ADD_LO, D_HOLD, WR_NONE, DIV_NONE);
      5'd16: c = mk(JC_NEXT, UPC_WAIT, MUL_NONE, ACC_ADD_HI, D_HOLD, WR_NONE, DIV_NONE);
      5'd17: c = mk(JC_NEXT, UPC_WAIT, MUL_NONE, ACC_HOLD, D_HOLD, WR_NONE, DIV_INIT);
      5'd18: c = mk(JC_LOOP, UPC_LOOP, MUL_NONE, ACC_HOLD, D_HOLD, WR_NONE, DIV_STEP);
      5'd19: c = mk(JC_OUT, UPC_WAIT, MUL_NONE, ACC_HOLD, D_HOLD, WR_RES_FUSE, DIV_NONE);
      5'd20: c = mk(JC_OUT, UPC_WAIT, MUL_NONE, ACC_HOLD, D_HOLD, WR_RES_CPU, DIV_NONE);
      default: c = mk(JC_JUMP, UPC_WAIT, MUL_NONE, ACC_HOLD, D_HOLD, WR_NONE, DIV_NONE);
    endcase
    return c;
  endfunction

endpackage

[rtl/frame_time_fusion.sv]
// frame time fusion top level: config registers, result register, sequencer
// depends on ftf_pkg, ftf_seq, ftf_dpath and frame_time_fusion_assert.svh
//
// One word on the input channel carries a CPU and a GPU frame time (UQ8.24 s);
// each gives exactly one result word: the chosen or blended time and a fused
// flag. Both channels use valid/stall; a word moves when valid is high and
// stall is low. The input stalls except while the sequencer waits for a word.
// Each word runs through a microcoded program over one 32x32 multiplier and a
// serial divider; when the blend is taken, the 32-step divide loop makes up most
// of the program, and when the CPU time passes the blend and divide are skipped.
// The result register is loaded at the last step; the next word is accepted
// while that result still waits. If the receiver stalls and a second result
// is ready, the sequencer holds on its last step until the register frees.
// Reset (rst_n, synchronous) restores the config defaults, empties the result
// register and clears the primed flag, so the first word seeds the averages.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12.
`include "frame_time_fusion_assert.svh"
module frame_time_fusion (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ftf_pkg::TW-1:0]     in_cpu_time,
  input  logic [ftf_pkg::TW-1:0]     in_gpu_time,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ftf_pkg::TW-1:0]     out_best_time,
  output logic                       out_fused,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ftf_pkg::CFG_AW-1:0] paddr,
  input  logic [ftf_pkg::TW-1:0]     pwdata,
  output logic [ftf_pkg::TW-1:0]     prdata,
  output logic                       pready
);
  import ftf_pkg::*;

  cfg_t          cfg_r;
  reg_idx_t      idx;
  logic          cfg_wr;
  uop_t          uop;
  stat_t         stat;
  logic          fuse, deliver, out_busy;
  logic [TW-1:0] res_best;
  logic          res_fused;
  logic          out_valid_r;
  logic [TW-1:0] out_best_r;
  logic          out_fused_r;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{keep: KEEP_RST, max_dev: MAXDEV_RST, gpu_limit: LIMIT_RST,
                 noise: NOISE_RST};
    end else if (cfg_wr) begin
      unique case (idx)
        REG_AVG_KEEP:  cfg_r.keep      <= pwdata[KW-1:0];
        REG_MAX_DEV:   cfg_r.max_dev   <= pwdata[KW-1:0];
        REG_GPU_LIMIT: cfg_r.gpu_limit <= pwdata;
        REG_NOISE:     cfg_r.noise     <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AVG_KEEP:  prdata = {16'b0, cfg_r.keep};
      REG_MAX_DEV:   prdata = {16'b0, cfg_r.max_dev};
      REG_GPU_LIMIT: prdata = cfg_r.gpu_limit;
      REG_NOISE:     prdata = cfg_r.noise;
      default:       prdata = '0;
    endcase
  end

  assign out_busy = out_valid_r && out_stall;
  assign stat     = '{in_valid: in_valid, fuse: fuse, out_busy: out_busy};
  assign in_stall = !rst_n || uop.cw.jc != JC_WAIT_IN;
  assign deliver  = uop.go && uop.cw.jc == JC_OUT;

  ftf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uop   (uop)
  );

  ftf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .uop       (uop),
    .cfg       (cfg_r),
    .cpu_time  (in_cpu_time),
    .gpu_time  (in_gpu_time),
    .fuse      (fuse),
    .res_best  (res_best),
    .res_fused (res_fused)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_best_r  <= res_best;
      out_fused_r <= res_fused;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_best_time = out_best_r;
  assign out_fused     = out_fused_r;

  // accepted word leaves the wait step at once
  `FTF_ASSERT_NXT(a_accept_leaves_wait, in_valid && !in_stall, uop.cw.jc != JC_WAIT_IN)
  // a waiting result is never overwritten
  `FTF_ASSERT_IMP(a_no_overwrite, deliver, !(out_valid_r && out_stall))

endmodule

[rtl/ftf_seq.sv]
// microcode sequencer: step counter, loop counter and control rom lookup
// depends on ftf_pkg
module ftf_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  ftf_pkg::stat_t stat,
  output ftf_pkg::uop_t  uop
);
  import ftf_pkg::*;

  upc_t            pc_r, pc_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  ctl_t            cw;
  logic            go;

  assign cw = ucode(pc_r);

  always_comb begin
    go      = 1'b1;
    pc_nxt  = pc_r + 5'd1;
    cnt_nxt = cnt_r;
    if (cw.div == DIV_INIT) begin
      cnt_nxt = DIV_LAST;
    end
    unique case (cw.jc)
      JC_NEXT: begin
        pc_nxt = pc_r + 5'd1;
      end
      JC_JUMP: begin
        pc_nxt = cw.target;
      end
      JC_WAIT_IN: begin
        go     = stat.in_valid;
        pc_nxt = stat.in_valid ? pc_r + 5'd1 : pc_r;
      end
      JC_SKIP: begin
        pc_nxt = stat.fuse ? pc_r + 5'd1 : cw.target;
      end
      JC_LOOP: begin
        if (cnt_r != '0) begin
          pc_nxt  = cw.target;
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      JC_OUT: begin
        go     = !stat.out_busy;
        pc_nxt = stat.out_busy ? pc_r : cw.target;
      end
      default: begin
        pc_nxt = UPC_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= UPC_WAIT;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign uop = '{cw: cw, go: go};

endmodule

[rtl/ftf_div.sv]
// serial restoring divider, one quotient bit per step, 32-bit quotient
// depends on ftf_pkg
module ftf_div (
  input  logic                     clk,
  input  ftf_pkg::div_op_t         op,
  input  logic                     den_ld,
  input  logic [ftf_pkg::PW-1:0]   dc,
  input  logic [ftf_pkg::PW-1:0]   dg,
  input  logic [ftf_pkg::ACCW-1:0] num,
  output logic [ftf_pkg::TW-1:0]   quot,
  output logic                     den_zero
);
  import ftf_pkg::*;

  logic [DENW-1:0] den_r;
  logic [DENW-1:0] rem_r;
  logic [TW-1:0]   q_r;
  logic [DENW:0]   trial;
  logic            fits;

  assign trial = {rem_r, q_r[TW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (den_ld) begin
      den_r <= {1'b0, dc} + {1'b0, dg};
    end
    case (op)
      DIV_INIT: begin
        rem_r <= num[ACCW-1:TW];
        q_r   <= num[TW-1:0];
      end
      DIV_STEP: begin
        if (fits) begin
          rem_r <= DENW'(trial - {1'b0, den_r});
        end else begin
          rem_r <= trial[DENW-1:0];
        end
        q_r <= {q_r[TW-2:0], fits};
      end
      default: begin
      end
    endcase
  end

  assign quot     = q_r;
  assign den_zero = den_r == '0;

endmodule

[rtl/ftf_dpath.sv]
// datapath: averages, shared 32x32 multiplier, accumulator, deviation terms
// depends on ftf_pkg and ftf_div
module ftf_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ftf_pkg::uop_t          uop,
  input  ftf_pkg::cfg_t          cfg,
  input  logic [ftf_pkg::TW-1:0] cpu_time,
  input  logic [ftf_pkg::TW-1:0] gpu_time,
  output logic                   fuse,
  output logic [ftf_pkg::TW-1:0] res_best,
  output logic                   res_fused
);
  import ftf_pkg::*;

  logic [TW-1:0]   c_r, g_r, avg_c_r, avg_g_r, prev_r, d_r;
  logic            primed_r, fuse_r, fuse_nxt;
  logic [PW-1:0]   prod_r, dc_r, dg_r;
  logic [ACCW-1:0] acc_r;
  logic [TW-1:0]   ma, mb, rest, da, db, d_nxt, quot;
  logic            accept, deliver, close, den_zero;

  assign accept  = uop.go && uop.cw.jc == JC_WAIT_IN;
  assign deliver = uop.go && uop.cw.jc == JC_OUT;
  assign rest    = KEEP_ONE - {16'b0, cfg.keep};

  always_comb begin
    ma = '0;
    mb = '0;
    case (uop.cw.mul)
      MUL_KEEP_AC: begin ma = {16'b0, cfg.keep};    mb = avg_c_r;          end
      MUL_REST_C:  begin ma = rest;                  mb = c_r;              end
      MUL_KEEP_AG: begin ma = {16'b0, cfg.keep};    mb = avg_g_r;          end
      MUL_REST_G:  begin ma = rest;                  mb = g_r;              end
      MUL_DEV:     begin ma = {16'b0, cfg.max_dev}; mb = avg_c_r;          end
      MUL_SQ:      begin ma = d_r;                   mb = d_r;              end
      MUL_C_DGL:   begin ma = c_r;                   mb = dg_r[TW-1:0];     end
      MUL_C_DGH:   begin ma = c_r;                   mb = dg_r[PW-1:TW];    end
      MUL_G_DCL:   begin ma = g_r;                   mb = dc_r[TW-1:0];     end
      MUL_G_DCH:   begin ma = g_r;                   mb = dc_r[PW-1:TW];    end
      default: begin
      end
    endcase
  end

  always_comb begin
    da = c_r;
    db = prev_r;
    case (uop.cw.dsel)
      D_GAP:   begin da = avg_g_r; db = avg_c_r; end
      D_GPREV: begin da = g_r;     db = prev_r;  end
      default: begin
      end
    endcase
    d_nxt = (da >= db) ? da - db : db - da;
  end

  assign close    = (avg_c_r == '0) ? (cfg.max_dev != '0)
                                    : ({d_r, 16'b0} < prod_r[47:0]);
  assign fuse_nxt = close && (g_r < cfg.gpu_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      fuse_r   <= 1'b0;
    end else begin
      if (accept) begin
        primed_r <= 1'b1;
      end
      if (uop.cw.wr == WR_FUSE) begin
        fuse_r <= fuse_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (accept) begin
      c_r <= cpu_time;
      g_r <= gpu_time;
      if (!primed_r) begin
        avg_c_r <= cpu_time;
        avg_g_r <= gpu_time;
        prev_r  <= cpu_time;
      end
    end
    case (uop.cw.acc)
      ACC_RND:    acc_r <= ROUND_HALF + {33'b0, prod_r};
      ACC_ADD_LO: acc_r <= acc_r + {33'b0, prod_r};
      ACC_ADD_HI: acc_r <= acc_r + {1'b0, prod_r, 32'b0};
      ACC_LOAD:   acc_r <= {33'b0, prod_r};
      default: begin
      end
    endcase
    if (uop.cw.dsel != D_HOLD) begin
      d_r <= d_nxt;
    end
    case (uop.cw.wr)
      WR_AVGC: avg_c_r <= acc_r[47:16];
      WR_AVGG: avg_g_r <= acc_r[47:16];
      WR_DC:   dc_r    <= prod_r + {32'b0, cfg.noise};
      WR_DG:   dg_r    <= prod_r + {32'b0, cfg.noise};
      WR_RES_FUSE, WR_RES_CPU: begin
        if (deliver) begin
          prev_r <= res_best;
        end
      end
      default: begin
      end
    endcase
  end

  ftf_div u_div (
    .clk      (clk),
    .op       (uop.cw.div),
    .den_ld   (uop.cw.wr == WR_DEN),
    .dc       (dc_r),
    .dg       (dg_r),
    .num      (acc_r),
    .quot     (quot),
    .den_zero (den_zero)
  );

  assign res_fused = uop.cw.wr == WR_RES_FUSE;
  assign res_best  = (res_fused && !den_zero) ? quot : c_r;
  assign fuse      = fuse_r;

endmodule

[bench/tb_top.sv]
// testbench for frame_time_fusion: directed table then random phases, each result checked
// against a typed row or a fused-frame-time predictor; register writes read back over apb
// depends on ftf_pkg and the frame_time_fusion rtl
`timescale 1ns / 100ps
module tb_top;
  import ftf_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 55;

  typedef struct packed {
    logic [TW-1:0] best_time;
    logic          fused;
  } frame_result_t;

  typedef enum logic [0:0] {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    reg_idx_t      which;
    logic [TW-1:0] a;
    logic [TW-1:0] b;
    logic          typed;
    logic [TW-1:0] best;
    logic          fused;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TW-1:0]     in_cpu_time = '0;
  logic [TW-1:0]     in_gpu_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TW-1:0]     out_best_time;
  logic              out_fused;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [TW-1:0]     pwdata = '0;
  logic [TW-1:0]     prdata;
  logic              pready;

  cfg_t            shadow = '{keep: KEEP_RST, max_dev: MAXDEV_RST, gpu_limit: LIMIT_RST,
                              noise: NOISE_RST};
  logic [TW-1:0]   avg_cpu_t = '0;
  logic [TW-1:0]   avg_gpu_t = '0;
  logic [TW-1:0]   last_best = '0;
  logic            seeded = 1'b0;
  frame_result_t   due_times[$];
  plan_row_t       plan[$];
  int              mismatches = 0;
  int              words_sent = 0;
  int              words_seen = 0;
  bit              tx_steady = 1'b0;
  bit              rx_steady = 1'b0;

  frame_time_fusion uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cpu_time  (in_cpu_time),
    .in_gpu_time  (in_gpu_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_best_time(out_best_time),
    .out_fused    (out_fused),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [TW-1:0] ema(logic [TW-1:0] old, logic [TW-1:0] x);
    logic [63:0] acc;
    acc = 64'(shadow.keep) * 64'(old) + (64'd65536 - 64'(shadow.keep)) * 64'(x) + 64'd32768;
    return acc[47:16];
  endfunction

  task automatic fuse_times(input logic [TW-1:0] c, input logic [TW-1:0] g,
                            output frame_result_t r);
    logic [63:0]  gap;
    logic [63:0]  dev;
    logic [63:0]  dc;
    logic [63:0]  dg;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    logic         close;
    if (!seeded) begin
      avg_cpu_t = c;
      avg_gpu_t = g;
      last_best = c;
      seeded = 1'b1;
    end
    avg_cpu_t = ema(avg_cpu_t, c);
    avg_gpu_t = ema(avg_gpu_t, g);
    if (avg_cpu_t == '0) begin
      close = (shadow.max_dev != '0);
    end else begin
      gap = (avg_gpu_t >= avg_cpu_t) ? 64'(avg_gpu_t - avg_cpu_t) : 64'(avg_cpu_t - avg_gpu_t);
      close = (gap << 16) < (64'(shadow.max_dev) * 64'(avg_cpu_t));
    end
    r.best_time = c;
    r.fused = close && (g < shadow.gpu_limit);
    if (r.fused) begin
      dev = (c >= last_best) ? 64'(c - last_best) : 64'(last_best - c);
      dc = dev * dev + 64'(shadow.noise);
      dev = (g >= last_best) ? 64'(g - last_best) : 64'(last_best - g);
      dg = dev * dev + 64'(shadow.noise);
      num = 128'(c) * 128'(dg) + 128'(g) * 128'(dc);
      den = 128'(dc) + 128'(dg);
      if (den != '0) begin
        quo = num / den;
        r.best_time = quo[TW-1:0];
      end
    end
    last_best = r.best_time;
  endtask

  // drop valid, then wait until every word has come back and the block is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_times.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t which, input logic [TW-1:0] v);
    logic [TW-1:0] readback;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (which)
      REG_AVG_KEEP:  shadow.keep = v[KW-1:0];
      REG_MAX_DEV:   shadow.max_dev = v[KW-1:0];
      REG_GPU_LIMIT: shadow.gpu_limit = v;
      REG_NOISE:     shadow.noise = v;
      default: ;
    endcase
    readback = (which == REG_AVG_KEEP || which == REG_MAX_DEV) ? {16'h0, v[KW-1:0]} : v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== readback) begin
      $error("prdata: expected %h, got %h", readback, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_frame(input logic [TW-1:0] c, input logic [TW-1:0] g,
                            input logic typed, input logic [TW-1:0] best, input logic fused);
    int gap;
    frame_result_t r;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cpu_time <= c;
    in_gpu_time <= g;
    do @(posedge clk); while (in_stall);
    fuse_times(c, g, r);
    if (typed) begin
      r.best_time = best;
      r.fused = fused;
    end
    due_times.push_back(r);
    words_sent++;
    if (words_sent % 25 == 0) tx_steady = ($urandom_range(0, 2) == 0);
  endtask

  function automatic logic [TW-1:0] draw_setting(logic [TW-1:0] lo, logic [TW-1:0] hi,
                                                 logic [TW-1:0] dflt);
    logic [TW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = lo;
      1: v = hi;
      2, 3: v = dflt;
      default: begin
        v = $urandom & hi;
        if (v < lo) v = lo;
      end
    endcase
    return v;
  endfunction

  // result side
  initial begin
    frame_result_t want;
    int hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = rx_steady ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (due_times.size() == 0) begin
        $error("unexpected word: best_time %h fused %b", out_best_time, out_fused);
        mismatches++;
      end else begin
        want = due_times.pop_front();
        if (out_best_time !== want.best_time) begin
          $error("best_time: expected %h, got %h", want.best_time, out_best_time);
          mismatches++;
        end
        if (out_fused !== want.fused) begin
          $error("fused: expected %b, got %b", want.fused, out_fused);
          mismatches++;
        end
      end
      words_seen++;
      if (words_seen % 32 == 0) rx_steady = ($urandom_range(0, 2) == 0);
    end
  end

  // stimulus
  initial begin
    plan_row_t row;
    logic [TW-1:0] c;
    logic [TW-1:0] g;
    logic [TW-1:0] base;
    int p;
    int n;

    // first word seeds the averages; zero cpu average
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h0, 32'h1000, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     32'hFFFF_FFFF, 1'b0});
    // gpu limit is strict
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h4_0000, 32'd284360, 1'b1, 32'h4_0000, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h4_0000, 32'd284359, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h4_5000, 32'h4_5100, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h1234_5678, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h4_0000, 32'h4_0000, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_REG, REG_NOISE, 32'h1, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_REG, REG_MAX_DEV, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0});
    // zero deviation limit never fuses
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h100, 32'h100, 1'b1, 32'h100, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0});
    plan.push_back('{ROW_REG, REG_MAX_DEV, 32'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_REG, REG_GPU_LIMIT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_REG, REG_AVG_KEEP, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h3_0000, 32'h3_0100, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h3_0000, 32'h3_0000, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_REG, REG_AVG_KEEP, 32'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_REG, REG_NOISE, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h4_0000, 32'h5_0000, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h4_1000, 32'h3_F000, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_REG, REG_GPU_LIMIT, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'h4_0000, 32'h0, 1'b1, 32'h4_0000, 1'b0});
    plan.push_back('{ROW_WORD, REG_AVG_KEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     32'hFFFF_FFFF, 1'b0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        wait_idle();
        apb_write(row.which, row.a);
      end else begin
        send_frame(row.a, row.b, row.typed, row.best, row.fused);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      apb_write(REG_AVG_KEEP, draw_setting(32'h0, 32'hFFFF, 32'(KEEP_RST)));
      apb_write(REG_MAX_DEV, draw_setting(32'h0, 32'hFFFF, 32'(MAXDEV_RST)));
      apb_write(REG_GPU_LIMIT, draw_setting(32'h0, 32'hFFFF_FFFF, 32'h0006_0000));
      apb_write(REG_NOISE, draw_setting(32'h1, 32'hFFFF_FFFF, NOISE_RST));
      base = $urandom_range(32'h2_0000, 32'h7_0000);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            c = $urandom;
            g = $urandom;
          end
          1: begin
            c = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            g = shadow.gpu_limit - $urandom_range(0, 1);
          end
          default: begin
            c = base + $urandom_range(0, 32'h4000) - 32'h2000;
            g = c + $urandom_range(0, 32'h2000) - 32'h1000;
            base = base + $urandom_range(0, 32'h800) - 32'h400;
          end
        endcase
        if ($urandom_range(0, 63) == 0) wait_idle();
        send_frame(c, g, 1'b0, '0, 1'b0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
